// File: hdl/c_style_token_scanner_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros used by the token scanner's group queue.
// Each macro expects signals named clk and arst_n in the using module.
// ----------------------------------------------------------------------------
`ifndef C_STYLE_TOKEN_SCANNER_UNIT_DEFINES_SVH
`define C_STYLE_TOKEN_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CSTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/csts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csts_pkg
// Types, constants and the per-byte scanning functions of the token scanner.
// ----------------------------------------------------------------------------
package csts_pkg;

	localparam int LINE_BITS   = 16;
	localparam int COLUMN_BITS = 16;
	localparam int MAXREC      = 4;
	localparam int QDEPTH      = 4;
	localparam int KW_COUNT    = 18;

	// Token kinds.
	localparam logic [5:0] K_EOF = 6'd0, K_ERROR = 6'd1, K_IDENT = 6'd2, K_NUMBER = 6'd3;
	localparam logic [5:0] K_FLOAT = 6'd4, K_STRING = 6'd5, K_CHAR = 6'd6;
	localparam logic [5:0] K_IF = 6'd7, K_ELSE = 6'd8, K_FOR = 6'd9, K_WHILE = 6'd10;
	localparam logic [5:0] K_RETURN = 6'd11, K_FUNCTION = 6'd12, K_VAR = 6'd13;
	localparam logic [5:0] K_CONST = 6'd14, K_CLASS = 6'd15, K_STRUCT = 6'd16;
	localparam logic [5:0] K_TRUE = 6'd17, K_FALSE = 6'd18, K_NULL = 6'd19, K_VOID = 6'd20;
	localparam logic [5:0] K_INT = 6'd21, K_BOOL = 6'd22;
	localparam logic [5:0] K_LPAREN = 6'd23, K_RPAREN = 6'd24, K_LBRACE = 6'd25;
	localparam logic [5:0] K_RBRACE = 6'd26, K_LBRACK = 6'd27, K_RBRACK = 6'd28;
	localparam logic [5:0] K_COMMA = 6'd29, K_SEMI = 6'd30, K_COLON = 6'd31;
	localparam logic [5:0] K_QUEST = 6'd32, K_DOT = 6'd33;
	localparam logic [5:0] K_ASSIGN = 6'd34, K_EQ = 6'd35, K_NOT = 6'd36, K_NE = 6'd37;
	localparam logic [5:0] K_LT = 6'd38, K_LE = 6'd39, K_SHL = 6'd40, K_GT = 6'd41;
	localparam logic [5:0] K_GE = 6'd42, K_SHR = 6'd43, K_AMP = 6'd44, K_LAND = 6'd45;
	localparam logic [5:0] K_PIPE = 6'd46, K_LOR = 6'd47, K_PLUS = 6'd48, K_INC = 6'd49;
	localparam logic [5:0] K_PLUSEQ = 6'd50, K_MINUS = 6'd51, K_DECR = 6'd52;
	localparam logic [5:0] K_MINUSEQ = 6'd53, K_ARROW = 6'd54, K_STAR = 6'd55;
	localparam logic [5:0] K_STAREQ = 6'd56, K_SLASH = 6'd57, K_SLASHEQ = 6'd58;
	localparam logic [5:0] K_PCT = 6'd59, K_PCTEQ = 6'd60, K_CARET = 6'd61, K_TILDE = 6'd62;

	// Keyword spellings, right-aligned, with their lengths and kinds.
	localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
		"if", "else", "for", "while", "return", "function", "var", "const",
		"class", "struct", "true", "false", "null", "void", "int", "float",
		"string", "bool"};
	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd2, 4'd4, 4'd3, 4'd5, 4'd6, 4'd8, 4'd3, 4'd5, 4'd5, 4'd6, 4'd4, 4'd5,
		4'd4, 4'd4, 4'd3, 4'd5, 4'd6, 4'd4};
	localparam logic [5:0] KW_KIND [KW_COUNT] = '{
		K_IF, K_ELSE, K_FOR, K_WHILE, K_RETURN, K_FUNCTION, K_VAR, K_CONST,
		K_CLASS, K_STRUCT, K_TRUE, K_FALSE, K_NULL, K_VOID, K_INT, K_FLOAT,
		K_STRING, K_BOOL};

	typedef enum logic [16:0] {
		M_IDLE      = 17'h00001,
		M_SLASH     = 17'h00002,
		M_OP        = 17'h00004,
		M_LCOM      = 17'h00008,
		M_BCOM      = 17'h00010,
		M_BSTAR     = 17'h00020,
		M_STR       = 17'h00040,
		M_CHR_OPEN  = 17'h00080,
		M_CHR_CLOSE = 17'h00100,
		M_IDENT     = 17'h00200,
		M_LEAD0     = 17'h00400,
		M_DEC       = 17'h00800,
		M_DOT       = 17'h01000,
		M_HEX       = 17'h02000,
		M_FRAC      = 17'h04000,
		M_EXP_SIGN  = 17'h08000,
		M_EXP_DIG   = 17'h10000
	} mode_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       byte_present;
		logic       end_of_source;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  value_byte;
		logic        value_present;
		logic        token_end;
		logic [5:0]  token_kind;
		logic [15:0] start_line;
		logic [15:0] start_column;
		logic        last_of_input;
	} out_item_t;

	// All records caused by one input item.
	typedef struct packed {
		out_item_t [MAXREC-1:0] recs;
		logic [2:0]             n;
	} grp_t;

	typedef struct packed {
		mode_t                  mode;
		logic [7:0]             la;
		logic [KW_COUNT-1:0]    kwc;
		logic [3:0]             ilen;
		logic                   esc;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic [LINE_BITS-1:0]   tok_line;
		logic [COLUMN_BITS-1:0] tok_col;
		logic [LINE_BITS-1:0]   held_line;
		logic [COLUMN_BITS-1:0] held_col;
	} scan_st_t;

	typedef struct packed {
		scan_st_t               st;
		out_item_t [MAXREC-1:0] recs;
		logic [2:0]             n;
		logic                   open_v;
		logic [1:0]             open_idx;
	} ctx_t;

	localparam scan_st_t ST_RESET = '{
		mode: M_IDLE, la: 8'd0, kwc: '1, ilen: 4'd0, esc: 1'b0,
		line: LINE_BITS'(1), col: COLUMN_BITS'(1),
		tok_line: LINE_BITS'(1), tok_col: COLUMN_BITS'(1),
		held_line: LINE_BITS'(1), held_col: COLUMN_BITS'(1)};

	// Character classes.
	function automatic logic is_digit(logic [7:0] b);
		return b inside {["0":"9"]};
	endfunction

	function automatic logic is_alpha(logic [7:0] b);
		return b inside {["a":"z"], ["A":"Z"]};
	endfunction

	function automatic logic is_xdigit(logic [7:0] b);
		return b inside {["0":"9"], ["a":"f"], ["A":"F"]};
	endfunction

	function automatic logic is_space(logic [7:0] b);
		return b inside {" ", [8'd9:8'd13]};
	endfunction

	function automatic logic [7:0] unescape(logic [7:0] b);
		logic [7:0] r;
		case (b)
			"n": r = 8'd10;
			"t": r = 8'd9;
			"r": r = 8'd13;
			"0": r = 8'd0;
			default: r = b;
		endcase
		return r;
	endfunction

	function automatic logic [5:0] op_single(logic [7:0] f);
		logic [5:0] k;
		case (f)
			"=": k = K_ASSIGN;
			"!": k = K_NOT;
			"<": k = K_LT;
			">": k = K_GT;
			"&": k = K_AMP;
			"|": k = K_PIPE;
			"+": k = K_PLUS;
			"-": k = K_MINUS;
			"*": k = K_STAR;
			"%": k = K_PCT;
			default: k = K_EOF;
		endcase
		return k;
	endfunction

	function automatic logic [5:0] op_pair(logic [7:0] f, logic [7:0] s);
		logic [5:0] k;
		k = K_EOF;
		if (f == "=" && s == "=") k = K_EQ;
		if (f == "!" && s == "=") k = K_NE;
		if (f == "<" && s == "=") k = K_LE;
		if (f == "<" && s == "<") k = K_SHL;
		if (f == ">" && s == "=") k = K_GE;
		if (f == ">" && s == ">") k = K_SHR;
		if (f == "&" && s == "&") k = K_LAND;
		if (f == "|" && s == "|") k = K_LOR;
		if (f == "+" && s == "+") k = K_INC;
		if (f == "+" && s == "=") k = K_PLUSEQ;
		if (f == "-" && s == "-") k = K_DECR;
		if (f == "-" && s == "=") k = K_MINUSEQ;
		if (f == "-" && s == ">") k = K_ARROW;
		if (f == "*" && s == "=") k = K_STAREQ;
		if (f == "%" && s == "=") k = K_PCTEQ;
		return k;
	endfunction

	function automatic logic [5:0] punct_kind(logic [7:0] b);
		logic [5:0] k;
		case (b)
			"(": k = K_LPAREN;
			")": k = K_RPAREN;
			"{": k = K_LBRACE;
			"}": k = K_RBRACE;
			"[": k = K_LBRACK;
			"]": k = K_RBRACK;
			",": k = K_COMMA;
			";": k = K_SEMI;
			":": k = K_COLON;
			"?": k = K_QUEST;
			".": k = K_DOT;
			"^": k = K_CARET;
			"~": k = K_TILDE;
			default: k = K_EOF;
		endcase
		return k;
	endfunction

	// Character j of keyword k; zero past the end of the word.
	function automatic logic [7:0] kw_char(int k, logic [3:0] j);
		logic [7:0] r;
		r = 8'd0;
		if (j < KW_LEN[k])
			r = KW_TEXT[k][8*(int'(KW_LEN[k]) - 1 - int'(j)) +: 8];
		return r;
	endfunction

	// Record building.
	function automatic ctx_t emit(ctx_t c, logic [7:0] b, logic p, logic e, logic [5:0] k);
		if (c.n < 3'(MAXREC)) begin
			c.recs[c.n[1:0]] = '{value_byte: b, value_present: p, token_end: e,
				token_kind: k, start_line: 16'(c.st.tok_line),
				start_column: 16'(c.st.tok_col), last_of_input: 1'b0};
			c.n = c.n + 3'd1;
		end
		return c;
	endfunction

	function automatic ctx_t val(ctx_t c, logic [7:0] b);
		c = emit(c, b, 1'b1, 1'b0, K_EOF);
		c.open_v = 1'b1;
		c.open_idx = 2'(c.n - 3'd1);
		return c;
	endfunction

	function automatic ctx_t close_tok(ctx_t c, logic [5:0] k);
		if (c.open_v && c.n != 3'd0 && c.open_idx == 2'(c.n - 3'd1)) begin
			c.recs[c.open_idx].token_end = 1'b1;
			c.recs[c.open_idx].token_kind = k;
		end else begin
			c = emit(c, 8'd0, 1'b0, 1'b1, k);
		end
		c.open_v = 1'b0;
		c.st.mode = M_IDLE;
		c.st.esc = 1'b0;
		return c;
	endfunction

	function automatic ctx_t ident_add(ctx_t c, logic [7:0] b);
		if (c.st.ilen >= 4'd9) begin
			c.st.kwc = '0;
		end else begin
			for (int k = 0; k < KW_COUNT; k++)
				if (kw_char(k, c.st.ilen) != b)
					c.st.kwc[k] = 1'b0;
		end
		if (c.st.ilen != 4'd15)
			c.st.ilen = c.st.ilen + 4'd1;
		return val(c, b);
	endfunction

	function automatic logic [5:0] ident_kind(scan_st_t st);
		logic [5:0] k;
		k = K_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--)
			if (st.kwc[i] && st.ilen == KW_LEN[i])
				k = KW_KIND[i];
		return k;
	endfunction

	// A byte seen between tokens.
	function automatic ctx_t idle_byte(ctx_t c, logic [7:0] b);
		c.st.mode = M_IDLE;
		if (!is_space(b)) begin
			c.st.tok_line = c.st.line;
			c.st.tok_col = c.st.col;
			c.open_v = 1'b0;
			if (b == "/") begin
				c.st.mode = M_SLASH;
			end else if (punct_kind(b) != K_EOF) begin
				c = val(c, b);
				c = close_tok(c, punct_kind(b));
			end else if (op_single(b) != K_EOF) begin
				c.st.la = b;
				c = val(c, b);
				c.st.mode = M_OP;
			end else if (b == "\"") begin
				c.st.esc = 1'b0;
				c.st.mode = M_STR;
			end else if (b == "'") begin
				c.st.esc = 1'b0;
				c.st.mode = M_CHR_OPEN;
			end else if (is_digit(b)) begin
				c = val(c, b);
				c.st.mode = (b == "0") ? M_LEAD0 : M_DEC;
			end else if (is_alpha(b) || b == "_") begin
				c.st.kwc = '1;
				c.st.ilen = 4'd0;
				c = ident_add(c, b);
				c.st.mode = M_IDENT;
			end else begin
				c = val(c, b);
				c = close_tok(c, K_ERROR);
			end
		end
		return c;
	endfunction

	// Number followed by a dot that does not start a fraction.
	function automatic ctx_t dot_not_float(ctx_t c);
		c = close_tok(c, K_NUMBER);
		c.st.tok_line = c.st.held_line;
		c.st.tok_col = c.st.held_col;
		c = val(c, ".");
		return close_tok(c, K_DOT);
	endfunction

	function automatic ctx_t step_byte(ctx_t c, logic [7:0] b);
		logic [5:0] k;
		k = op_pair(c.st.la, b);
		case (c.st.mode)
			M_SLASH: begin
				if (b == "/") c.st.mode = M_LCOM;
				else if (b == "*") c.st.mode = M_BCOM;
				else if (b == "=") begin
					c = val(c, "/");
					c = val(c, "=");
					c = close_tok(c, K_SLASHEQ);
				end else begin
					c = val(c, "/");
					c = close_tok(c, K_SLASH);
					c = idle_byte(c, b);
				end
			end
			M_OP: begin
				if (k != K_EOF) begin
					c = val(c, b);
					c = close_tok(c, k);
				end else begin
					c = close_tok(c, op_single(c.st.la));
					c = idle_byte(c, b);
				end
			end
			M_LCOM: begin
				if (b == 8'd10) c.st.mode = M_IDLE;
			end
			M_BCOM: begin
				if (b == "*") c.st.mode = M_BSTAR;
			end
			M_BSTAR: begin
				if (b == "/") c.st.mode = M_IDLE;
				else if (b != "*") c.st.mode = M_BCOM;
			end
			M_STR: begin
				if (c.st.esc) begin
					c.st.esc = 1'b0;
					if (b == 8'd0) begin
						c = val(c, "\\");
						c = val(c, 8'd0);
					end else begin
						c = val(c, unescape(b));
					end
				end else if (b == "\"") c = close_tok(c, K_STRING);
				else if (b == "\\") c.st.esc = 1'b1;
				else c = val(c, b);
			end
			M_CHR_OPEN: begin
				if (c.st.esc) begin
					c.st.esc = 1'b0;
					c = val(c, unescape(b));
					c.st.mode = M_CHR_CLOSE;
				end else if (b == "\\") c.st.esc = 1'b1;
				else begin
					c = val(c, b);
					c.st.mode = M_CHR_CLOSE;
				end
			end
			M_CHR_CLOSE: begin
				c = close_tok(c, K_CHAR);
				if (b != "'") c = idle_byte(c, b);
			end
			M_IDENT: begin
				if (is_alpha(b) || is_digit(b) || b == "_") c = ident_add(c, b);
				else begin
					c = close_tok(c, ident_kind(c.st));
					c = idle_byte(c, b);
				end
			end
			M_LEAD0, M_DEC: begin
				if (c.st.mode == M_LEAD0 && (b == "x" || b == "X")) begin
					c = val(c, b);
					c.st.mode = M_HEX;
				end else if (is_digit(b)) begin
					c = val(c, b);
					c.st.mode = M_DEC;
				end else if (b == ".") begin
					c.st.held_line = c.st.line;
					c.st.held_col = c.st.col;
					c.st.mode = M_DOT;
				end else begin
					c = close_tok(c, K_NUMBER);
					c = idle_byte(c, b);
				end
			end
			M_DOT: begin
				if (is_digit(b)) begin
					c = val(c, ".");
					c = val(c, b);
					c.st.mode = M_FRAC;
				end else begin
					c = dot_not_float(c);
					c = idle_byte(c, b);
				end
			end
			M_HEX: begin
				if (is_xdigit(b)) c = val(c, b);
				else begin
					c = close_tok(c, K_NUMBER);
					c = idle_byte(c, b);
				end
			end
			M_FRAC: begin
				if (is_digit(b)) c = val(c, b);
				else if (b == "e" || b == "E") begin
					c = val(c, b);
					c.st.mode = M_EXP_SIGN;
				end else begin
					c = close_tok(c, K_FLOAT);
					c = idle_byte(c, b);
				end
			end
			M_EXP_SIGN: begin
				if (b == "+" || b == "-" || is_digit(b)) begin
					c = val(c, b);
					c.st.mode = M_EXP_DIG;
				end else begin
					c = close_tok(c, K_FLOAT);
					c = idle_byte(c, b);
				end
			end
			M_EXP_DIG: begin
				if (is_digit(b)) c = val(c, b);
				else begin
					c = close_tok(c, K_FLOAT);
					c = idle_byte(c, b);
				end
			end
			default: c = idle_byte(c, b);
		endcase
		return c;
	endfunction

	// Close whatever token is open when the source ends.
	function automatic ctx_t flush(ctx_t c);
		case (c.st.mode)
			M_SLASH: begin
				c = val(c, "/");
				c = close_tok(c, K_SLASH);
			end
			M_OP: c = close_tok(c, op_single(c.st.la));
			M_STR: begin
				if (c.st.esc) c = val(c, "\\");
				c = close_tok(c, K_STRING);
			end
			M_CHR_OPEN: begin
				if (c.st.esc) c = val(c, "\\");
				c = close_tok(c, K_CHAR);
			end
			M_CHR_CLOSE: c = close_tok(c, K_CHAR);
			M_IDENT: c = close_tok(c, ident_kind(c.st));
			M_LEAD0, M_DEC, M_HEX: c = close_tok(c, K_NUMBER);
			M_DOT: c = dot_not_float(c);
			M_FRAC, M_EXP_SIGN, M_EXP_DIG: c = close_tok(c, K_FLOAT);
			default: c.st.mode = M_IDLE;
		endcase
		return c;
	endfunction

	// Saturating line and column counters.
	function automatic scan_st_t advance(scan_st_t st, logic [7:0] b);
		if (b == 8'd10) begin
			if (st.line != '1) st.line = st.line + LINE_BITS'(1);
			st.col = COLUMN_BITS'(1);
		end else if (st.col != '1) begin
			st.col = st.col + COLUMN_BITS'(1);
		end
		return st;
	endfunction

	// Full effect of one input item.
	function automatic ctx_t scan_item(scan_st_t st, in_item_t it);
		ctx_t c;
		c.st = st;
		c.recs = '0;
		c.n = 3'd0;
		c.open_v = 1'b0;
		c.open_idx = 2'd0;
		if (it.byte_present) begin
			c = step_byte(c, it.in_byte);
			c.st = advance(c.st, it.in_byte);
		end
		if (it.end_of_source) begin
			c = flush(c);
			c.st.tok_line = c.st.line;
			c.st.tok_col = c.st.col;
			c.open_v = 1'b0;
			c = emit(c, 8'd0, 1'b0, 1'b1, K_EOF);
			c.st = ST_RESET;
		end
		if (c.n != 3'd0)
			c.recs[2'(c.n - 3'd1)].last_of_input = 1'b1;
		return c;
	endfunction

endpackage

// File: hdl/csts_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csts_front
// Accepts source bytes, runs the lexer state and builds each byte's records.
// ----------------------------------------------------------------------------
module csts_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_ready,
	input  csts_pkg::in_item_t src_data,
	input  logic               q_full,
	output logic               q_push,
	output csts_pkg::grp_t     q_wdata
);

	csts_pkg::scan_st_t st_q;
	csts_pkg::ctx_t     nxt;
	logic               take;

	// Work out all records of the offered item from the current state.
	always_comb begin
		nxt = csts_pkg::scan_item(st_q, src_data);
	end

	assign src_ready = !q_full;
	assign take      = src_valid && src_ready;
	assign q_push    = take && (nxt.n != 3'd0);
	assign q_wdata   = '{recs: nxt.recs, n: nxt.n};

	// Lexer state advances on each transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= csts_pkg::ST_RESET;
		end else if (take) begin
			st_q <= nxt.st;
		end
	end

endmodule

// File: hdl/csts_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csts_fifo
// Short queue of record groups between the front and the back.
// ----------------------------------------------------------------------------
`include "c_style_token_scanner_unit_defines.svh"

module csts_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  csts_pkg::grp_t wdata,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output csts_pkg::grp_t rdata
);

	csts_pkg::grp_t mem_q [csts_pkg::QDEPTH];
	logic [1:0]     wr_ptr_q;
	logic [1:0]     rd_ptr_q;
	logic [2:0]     cnt_q;

	assign full  = (cnt_q == 3'(csts_pkg::QDEPTH));
	assign empty = (cnt_q == 3'd0);
	assign rdata = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			cnt_q    <= 3'd0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (pop) rd_ptr_q <= rd_ptr_q + 2'd1;
			if (push && !pop) cnt_q <= cnt_q + 3'd1;
			else if (pop && !push) cnt_q <= cnt_q - 3'd1;
		end
	end

	`CSTS_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into a full queue")
	`CSTS_ASSERT_NOW(a_no_underflow, pop, !empty, "pop from an empty queue")
	`CSTS_ASSERT_NOW(a_group_nonempty, push, wdata.n != 3'd0, "empty group queued")
	`CSTS_ASSERT_NEXT(a_count_up, push && !pop, cnt_q == $past(cnt_q) + 3'd1, "count slip")

endmodule

// File: hdl/csts_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csts_back
// Takes record groups from the queue and sends them out one record at a time.
// ----------------------------------------------------------------------------
module csts_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  csts_pkg::grp_t      q_rdata,
	output logic                q_pop,
	output logic                tok_valid,
	input  logic                tok_ready,
	output csts_pkg::out_item_t tok_data
);

	csts_pkg::grp_t cur_q;
	logic [1:0]     idx_q;
	logic           cur_v_q;
	logic           last;
	logic           sent;

	assign last      = (idx_q == 2'(cur_q.n - 3'd1));
	assign sent      = cur_v_q && tok_ready;
	assign q_pop     = !q_empty && (!cur_v_q || (sent && last));
	assign tok_valid = cur_v_q;
	assign tok_data  = cur_q.recs[idx_q];

	// Group payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_rdata;
		end
	end

	// Record index and valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (q_pop) begin
			cur_v_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (sent) begin
			if (last) cur_v_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

endmodule

// File: hdl/c_style_token_scanner_unit.sv
// Records are registered in the group queue, then in the back end's group
// register. Throughput: one source byte per cycle while the group queue has
// room; the output sends one record per cycle while tok_ready is high, so
// bytes with up to four records are paced by the serialiser in the back end.
// Reset: asynchronous, active low; lexer at line 1 column 1, queue empty.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_style_token_scanner_unit
// Streaming lexer: front scanner, group queue and record serialiser.
// ----------------------------------------------------------------------------
module c_style_token_scanner_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                src_valid,
	output logic                src_ready,
	input  csts_pkg::in_item_t  src_data,
	output logic                tok_valid,
	input  logic                tok_ready,
	output csts_pkg::out_item_t tok_data
);

	logic           q_full;
	logic           q_empty;
	logic           q_push;
	logic           q_pop;
	csts_pkg::grp_t q_wdata;
	csts_pkg::grp_t q_rdata;

	// Front: scan bytes into record groups.
	csts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdata   (q_wdata)
	);

	// Queue between the two halves.
	csts_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	// Back: one record per transfer.
	csts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_rdata   (q_rdata),
		.q_pop     (q_pop),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Token scanner testbench
// Drives source bytes into the scanner and checks every token record
// against a lexer model held here. Directed cases come first, then random
// source text, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

	// Lexer modes held by the model.
	typedef enum int {
		S_IDLE, S_SLASH, S_OP, S_LCOM, S_BCOM, S_BSTAR, S_STR, S_CHO, S_CHC,
		S_IDENT, S_LEAD0, S_DEC, S_DOT, S_HEX, S_FRAC, S_EXPS, S_EXPD
	} lex_mode_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_ready;
	csts_pkg::in_item_t src_data = '0;
	logic tok_valid;
	logic tok_ready = 1'b0;
	csts_pkg::out_item_t tok_data;

	c_style_token_scanner_unit dut (
		.clk(clk), .arst_n(arst_n),
		.src_valid(src_valid), .src_ready(src_ready), .src_data(src_data),
		.tok_valid(tok_valid), .tok_ready(tok_ready), .tok_data(tok_data)
	);

	always #5 clk = ~clk;

	// Lexer model state.
	lex_mode_t lx_mode;
	logic [7:0] lx_op;
	logic [17:0] lx_kwc;
	int lx_len;
	bit lx_esc;
	logic [15:0] lx_line, lx_col, lx_tline, lx_tcol, lx_hline, lx_hcol;
	csts_pkg::out_item_t rec_buf [4];
	int rec_n;
	int open_idx;

	csts_pkg::out_item_t expected_records [$];
	int error_count = 0;
	bit no_idle = 1'b0;
	bit done = 1'b0;

	string kw_words [18] = '{"if", "else", "for", "while", "return", "function",
		"var", "const", "class", "struct", "true", "false", "null", "void", "int",
		"float", "string", "bool"};
	logic [5:0] kw_kinds [18] = '{csts_pkg::K_IF, csts_pkg::K_ELSE, csts_pkg::K_FOR,
		csts_pkg::K_WHILE, csts_pkg::K_RETURN, csts_pkg::K_FUNCTION, csts_pkg::K_VAR,
		csts_pkg::K_CONST, csts_pkg::K_CLASS, csts_pkg::K_STRUCT, csts_pkg::K_TRUE,
		csts_pkg::K_FALSE, csts_pkg::K_NULL, csts_pkg::K_VOID, csts_pkg::K_INT,
		csts_pkg::K_FLOAT, csts_pkg::K_STRING, csts_pkg::K_BOOL};

	function automatic void lex_reset();
		lx_mode = S_IDLE;
		lx_op = 8'd0;
		lx_kwc = '1;
		lx_len = 0;
		lx_esc = 1'b0;
		lx_line = 16'd1; lx_col = 16'd1;
		lx_tline = 16'd1; lx_tcol = 16'd1;
		lx_hline = 16'd1; lx_hcol = 16'd1;
	endfunction

	function automatic bit dig(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit alpha(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic void put(logic [7:0] b, bit p, bit e, logic [5:0] k);
		if (rec_n < 4) begin
			rec_buf[rec_n] = '{value_byte: p ? b : 8'd0, value_present: p, token_end: e,
				token_kind: k, start_line: lx_tline, start_column: lx_tcol,
				last_of_input: 1'b0};
			rec_n++;
		end
	endfunction

	function automatic void add_value(logic [7:0] b);
		put(b, 1'b1, 1'b0, csts_pkg::K_EOF);
		open_idx = rec_n - 1;
	endfunction

	function automatic void close_token(logic [5:0] k);
		if (open_idx >= 0 && open_idx == rec_n - 1) begin
			rec_buf[open_idx].token_end = 1'b1;
			rec_buf[open_idx].token_kind = k;
		end else begin
			put(8'd0, 1'b0, 1'b1, k);
		end
		open_idx = -1;
		lx_mode = S_IDLE;
		lx_esc = 1'b0;
	endfunction

	function automatic logic [5:0] single_kind(logic [7:0] f);
		case (f)
			"=": return csts_pkg::K_ASSIGN;
			"!": return csts_pkg::K_NOT;
			"<": return csts_pkg::K_LT;
			">": return csts_pkg::K_GT;
			"&": return csts_pkg::K_AMP;
			"|": return csts_pkg::K_PIPE;
			"+": return csts_pkg::K_PLUS;
			"-": return csts_pkg::K_MINUS;
			"*": return csts_pkg::K_STAR;
			"%": return csts_pkg::K_PCT;
			default: return csts_pkg::K_EOF;
		endcase
	endfunction

	function automatic logic [5:0] pair_kind(logic [7:0] f, logic [7:0] s);
		string two;
		two = {string'(f), string'(s)};
		case (two)
			"==": return csts_pkg::K_EQ;
			"!=": return csts_pkg::K_NE;
			"<=": return csts_pkg::K_LE;
			"<<": return csts_pkg::K_SHL;
			">=": return csts_pkg::K_GE;
			">>": return csts_pkg::K_SHR;
			"&&": return csts_pkg::K_LAND;
			"||": return csts_pkg::K_LOR;
			"++": return csts_pkg::K_INC;
			"+=": return csts_pkg::K_PLUSEQ;
			"--": return csts_pkg::K_DECR;
			"-=": return csts_pkg::K_MINUSEQ;
			"->": return csts_pkg::K_ARROW;
			"*=": return csts_pkg::K_STAREQ;
			"%=": return csts_pkg::K_PCTEQ;
			default: return csts_pkg::K_EOF;
		endcase
	endfunction

	function automatic logic [5:0] mark_kind(logic [7:0] b);
		case (b)
			"(": return csts_pkg::K_LPAREN;
			")": return csts_pkg::K_RPAREN;
			"{": return csts_pkg::K_LBRACE;
			"}": return csts_pkg::K_RBRACE;
			"[": return csts_pkg::K_LBRACK;
			"]": return csts_pkg::K_RBRACK;
			",": return csts_pkg::K_COMMA;
			";": return csts_pkg::K_SEMI;
			":": return csts_pkg::K_COLON;
			"?": return csts_pkg::K_QUEST;
			".": return csts_pkg::K_DOT;
			"^": return csts_pkg::K_CARET;
			"~": return csts_pkg::K_TILDE;
			default: return csts_pkg::K_EOF;
		endcase
	endfunction

	function automatic logic [7:0] decode_escape(logic [7:0] b);
		case (b)
			"n": return 8'd10;
			"t": return 8'd9;
			"r": return 8'd13;
			"0": return 8'd0;
			default: return b;
		endcase
	endfunction

	// Narrow the keyword candidates by one more identifier character.
	function automatic void word_add(logic [7:0] b);
		logic [7:0] c;
		if (lx_len >= 9) begin
			lx_kwc = '0;
		end else begin
			for (int k = 0; k < 18; k++) begin
				c = (lx_len < kw_words[k].len()) ? kw_words[k][lx_len] : 8'd0;
				if (c != b)
					lx_kwc[k] = 1'b0;
			end
		end
		if (lx_len < 15)
			lx_len++;
		add_value(b);
	endfunction

	function automatic logic [5:0] word_kind();
		if (lx_len < 9)
			for (int k = 0; k < 18; k++)
				if (lx_kwc[k] && kw_words[k].len() == lx_len)
					return kw_kinds[k];
		return csts_pkg::K_IDENT;
	endfunction

	function automatic void begin_token(logic [7:0] b);
		lx_mode = S_IDLE;
		if (b == " " || (b >= 8'd9 && b <= 8'd13))
			return;
		lx_tline = lx_line;
		lx_tcol = lx_col;
		open_idx = -1;
		if (b == "/") begin
			lx_mode = S_SLASH;
		end else if (mark_kind(b) != csts_pkg::K_EOF) begin
			add_value(b);
			close_token(mark_kind(b));
		end else if (single_kind(b) != csts_pkg::K_EOF) begin
			lx_op = b;
			add_value(b);
			lx_mode = S_OP;
		end else if (b == "\"") begin
			lx_esc = 1'b0;
			lx_mode = S_STR;
		end else if (b == "'") begin
			lx_esc = 1'b0;
			lx_mode = S_CHO;
		end else if (dig(b)) begin
			add_value(b);
			lx_mode = (b == "0") ? S_LEAD0 : S_DEC;
		end else if (alpha(b) || b == "_") begin
			lx_kwc = '1;
			lx_len = 0;
			word_add(b);
			lx_mode = S_IDENT;
		end else begin
			add_value(b);
			close_token(csts_pkg::K_ERROR);
		end
	endfunction

	// A number followed by a dot that does not begin a fraction.
	function automatic void split_dot();
		close_token(csts_pkg::K_NUMBER);
		lx_tline = lx_hline;
		lx_tcol = lx_hcol;
		add_value(".");
		close_token(csts_pkg::K_DOT);
	endfunction

	function automatic void scan_byte(logic [7:0] b);
		logic [5:0] k;
		case (lx_mode)
			S_SLASH: begin
				if (b == "/") lx_mode = S_LCOM;
				else if (b == "*") lx_mode = S_BCOM;
				else if (b == "=") begin
					add_value("/"); add_value("="); close_token(csts_pkg::K_SLASHEQ);
				end else begin
					add_value("/"); close_token(csts_pkg::K_SLASH); begin_token(b);
				end
			end
			S_OP: begin
				k = pair_kind(lx_op, b);
				if (k != csts_pkg::K_EOF) begin
					add_value(b); close_token(k);
				end else begin
					close_token(single_kind(lx_op)); begin_token(b);
				end
			end
			S_LCOM: if (b == 8'd10) lx_mode = S_IDLE;
			S_BCOM: if (b == "*") lx_mode = S_BSTAR;
			S_BSTAR: begin
				if (b == "/") lx_mode = S_IDLE;
				else if (b != "*") lx_mode = S_BCOM;
			end
			S_STR: begin
				if (lx_esc) begin
					lx_esc = 1'b0;
					if (b == 8'd0) begin
						add_value("\\"); add_value(8'd0);
					end else begin
						add_value(decode_escape(b));
					end
				end else if (b == "\"") close_token(csts_pkg::K_STRING);
				else if (b == "\\") lx_esc = 1'b1;
				else add_value(b);
			end
			S_CHO: begin
				if (lx_esc) begin
					lx_esc = 1'b0; add_value(decode_escape(b)); lx_mode = S_CHC;
				end else if (b == "\\") lx_esc = 1'b1;
				else begin
					add_value(b); lx_mode = S_CHC;
				end
			end
			S_CHC: begin
				close_token(csts_pkg::K_CHAR);
				if (b != "'") begin_token(b);
			end
			S_IDENT: begin
				if (alpha(b) || dig(b) || b == "_") word_add(b);
				else begin
					close_token(word_kind()); begin_token(b);
				end
			end
			S_LEAD0, S_DEC: begin
				if (lx_mode == S_LEAD0 && (b == "x" || b == "X")) begin
					add_value(b); lx_mode = S_HEX;
				end else if (dig(b)) begin
					add_value(b); lx_mode = S_DEC;
				end else if (b == ".") begin
					lx_hline = lx_line; lx_hcol = lx_col; lx_mode = S_DOT;
				end else begin
					close_token(csts_pkg::K_NUMBER); begin_token(b);
				end
			end
			S_DOT: begin
				if (dig(b)) begin
					add_value("."); add_value(b); lx_mode = S_FRAC;
				end else begin
					split_dot(); begin_token(b);
				end
			end
			S_HEX: begin
				if (dig(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F")) add_value(b);
				else begin
					close_token(csts_pkg::K_NUMBER); begin_token(b);
				end
			end
			S_FRAC: begin
				if (dig(b)) add_value(b);
				else if (b == "e" || b == "E") begin
					add_value(b); lx_mode = S_EXPS;
				end else begin
					close_token(csts_pkg::K_FLOAT); begin_token(b);
				end
			end
			S_EXPS: begin
				if (b == "+" || b == "-" || dig(b)) begin
					add_value(b); lx_mode = S_EXPD;
				end else begin
					close_token(csts_pkg::K_FLOAT); begin_token(b);
				end
			end
			S_EXPD: begin
				if (dig(b)) add_value(b);
				else begin
					close_token(csts_pkg::K_FLOAT); begin_token(b);
				end
			end
			default: begin_token(b);
		endcase
	endfunction

	function automatic void flush_token();
		case (lx_mode)
			S_SLASH: begin
				add_value("/"); close_token(csts_pkg::K_SLASH);
			end
			S_OP: close_token(single_kind(lx_op));
			S_STR: begin
				if (lx_esc) add_value("\\");
				close_token(csts_pkg::K_STRING);
			end
			S_CHO: begin
				if (lx_esc) add_value("\\");
				close_token(csts_pkg::K_CHAR);
			end
			S_CHC: close_token(csts_pkg::K_CHAR);
			S_IDENT: close_token(word_kind());
			S_LEAD0, S_DEC, S_HEX: close_token(csts_pkg::K_NUMBER);
			S_DOT: split_dot();
			S_FRAC, S_EXPS, S_EXPD: close_token(csts_pkg::K_FLOAT);
			default: lx_mode = S_IDLE;
		endcase
	endfunction

	// Work out the records caused by one source item and queue them.
	function automatic void predict_records(csts_pkg::in_item_t it);
		rec_n = 0;
		open_idx = -1;
		if (it.byte_present) begin
			scan_byte(it.in_byte);
			if (it.in_byte == 8'd10) begin
				if (lx_line != 16'hFFFF) lx_line++;
				lx_col = 16'd1;
			end else if (lx_col != 16'hFFFF) begin
				lx_col++;
			end
		end
		if (it.end_of_source) begin
			flush_token();
			lx_tline = lx_line;
			lx_tcol = lx_col;
			open_idx = -1;
			put(8'd0, 1'b0, 1'b1, csts_pkg::K_EOF);
			lex_reset();
		end
		if (rec_n > 0)
			rec_buf[rec_n - 1].last_of_input = 1'b1;
		for (int i = 0; i < rec_n; i++)
			expected_records = {expected_records, rec_buf[i]};
	endfunction

	// Send one source item; the model runs at the transfer. Valid stays high
	// after a transfer until the next item or an idle cycle replaces it.
	task automatic send_item(logic [7:0] b, bit p, bit e);
		while (!no_idle && $urandom_range(99) < 13) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= '{in_byte: b, byte_present: p, end_of_source: e};
		@(posedge clk);
		while (!src_ready)
			@(posedge clk);
		predict_records('{in_byte: b, byte_present: p, end_of_source: e});
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b1, 1'b0);
	endtask

	task automatic end_source();
		send_item(8'd0, 1'b0, 1'b1);
	endtask

	// Stop sending and wait until every expected record has come out.
	task automatic wait_drained();
		src_valid <= 1'b0;
		@(posedge clk);
		while (expected_records.size() != 0)
			@(posedge clk);
	endtask

	// Operators, punctuation, keywords and comments.
	task automatic test_operators_and_words();
		send_text("a==b!=c<=<<>=>>&&||++ +=--->*=%=/=/ ^~();");
		no_idle = 1'b1;
		send_text("if else\nfunction struct const/*x**/while//c\nret_9 x1234567890");
		no_idle = 1'b0;
		end_source();
	endtask

	// Numbers, literals with escapes, unknown bytes and the end cases.
	task automatic test_literals();
		send_text("0x1F 12.5e+3 7.e 12.x \"a\\n\\");
		send_item(8'd0, 1'b1, 1'b0);
		send_text("\\q\" 'z 'b'");
		send_item(8'd255, 1'b1, 1'b0);
		send_item(8'd0, 1'b1, 1'b0);
		send_item(8'd128, 1'b0, 1'b0);
		send_text("@\"x\\");
		end_source();
		send_text("3.");
		send_item("4", 1'b1, 1'b1);
		send_text("'\\");
		end_source();
	endtask

	// Random source text: mostly well-formed fragments, some noise.
	task automatic test_random_text();
		string frags [16] = '{"while", "x_1 ", "0x9aF", "3.14e-2", "\"s\\t\"", "'c'",
			"/*c*/", "//z\n", "->", "+=", "\n", " ", "return", "12.", "(", "bool"};
		int n;
		n = 0;
		while (n < 30) begin
			if ($urandom_range(9) < 7) begin
				send_text(frags[$urandom_range(15)]);
				n += 3;
			end else begin
				send_item(8'($urandom), 1'($urandom), 1'b0);
				n++;
			end
			if ($urandom_range(29) == 0) begin
				end_source();
				if ($urandom_range(1) == 1)
					wait_drained();
			end
		end
		end_source();
		wait_drained();
	endtask

	// Output side: random stalls and the record check.
	always @(posedge clk) begin
		if (arst_n) begin
			if (tok_valid && tok_ready) begin
				if (expected_records.size() == 0) begin
					$display("%0t: unexpected record, expected none, actual %h", $time,
						tok_data);
					error_count++;
				end else if (tok_data !== expected_records[0]) begin
					$display("%0t: record mismatch, expected %p, actual %p", $time,
						expected_records[0], tok_data);
					error_count++;
					void'(expected_records.pop_front());
				end else begin
					void'(expected_records.pop_front());
				end
			end
			tok_ready <= no_idle || ($urandom_range(99) >= 13);
		end
	end

	// Watchdog on cycles with no transfer.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((src_valid && src_ready) || (tok_valid && tok_ready) || !arst_n || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		lex_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_operators_and_words();
		test_literals();
		wait_drained();
		test_random_text();
		done = 1'b1;
		repeat (20) @(posedge clk);
		if (error_count == 0 && expected_records.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
